>>> hdl/multi_timer_expiry_scheduler_macros.svh
// Assertion macros for the timer expiry scheduler.
// Define ASSERT_OFF to compile every assertion away; no other dependencies.
`ifndef MULTI_TIMER_EXPIRY_SCHEDULER_MACROS_SVH
`define MULTI_TIMER_EXPIRY_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clock edge, disabled while reset is low
`define MTES_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next
`define MTES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MTES_ASSERT(lbl, clk, rst_n, prop, msg)
`define MTES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/mtes_pkg.sv
// Shared types and fixed field widths of the timer expiry scheduler.
// No dependencies.
package mtes_pkg;

  // Field widths fixed by the item format
  localparam int ID_W       = 4;
  localparam int PERIOD_W   = 31;
  localparam int STAMP_W    = 32;
  localparam int OUT_TIME_W = 48;

  // Input item operations
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_TICK  = 2'd2
  } act_e;

endpackage

>>> hdl/mtes_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mtes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/multi_timer_expiry_scheduler.sv
// Deadline-ordered timer queue: slot RAM, armed bits and the tick sequencer.
// Depends on mtes_pkg, mtes_ram and multi_timer_expiry_scheduler_macros.svh.
//
// Start and stop items complete without leaving the idle state. A tick scans
// the slot RAM once per fired timer through its single read port, one slot
// per cycle, and picks the earliest expiry (newest stamp on a tie, lowest slot
// after that) with one shared comparator. Each result waits until the result
// register has drained. The input is not ready until the tick has emitted its
// last result; the final result may still sit in the output register while
// the next item is taken.
`include "multi_timer_expiry_scheduler_macros.svh"

module multi_timer_expiry_scheduler #(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_BITS  = 48
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          action_i,
  input  logic [mtes_pkg::ID_W-1:0]           timer_id_i,
  input  logic [mtes_pkg::PERIOD_W-1:0]       interval_ms_i,
  input  logic                                one_shot_i,
  input  logic [mtes_pkg::OUT_TIME_W-1:0]     now_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mtes_pkg::ID_W-1:0]           fired_id_o,
  output logic [mtes_pkg::OUT_TIME_W-1:0]     fired_deadline_o,
  output logic                                last_of_tick_o
);

  import mtes_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int SUM_W = ((TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W) + 1;

  typedef struct packed {
    logic [TIME_BITS-1:0] expiry;
    logic [STAMP_W-1:0]   stamp;
    logic [PERIOD_W-1:0]  period;
    logic                 single;
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e                state_q, state_d;
  logic [NUM_TIMERS-1:0] armed_q, armed_d;
  logic [NUM_TIMERS-1:0] due_q, due_d;
  logic [STAMP_W-1:0]    stamp_q, stamp_d;
  logic [TIME_BITS-1:0]  now_q, now_d;
  logic [CNT_W-1:0]      scan_cnt_q, scan_cnt_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]      rd_idx_q, rd_idx_d;
  logic                  found_q, found_d;
  logic [IDX_W-1:0]      best_idx_q, best_idx_d;
  slot_t                 best_rec_q, best_rec_d;
  logic                  out_valid_q, out_valid_d;
  logic [ID_W-1:0]       out_id_q, out_id_d;
  logic [OUT_TIME_W-1:0] out_dl_q, out_dl_d;
  logic                  out_last_q, out_last_d;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  slot_t                 ram_wdata;
  slot_t                 rd_rec;

  logic [IDX_W-1:0]      id_idx;
  logic                  id_ok;
  logic [PERIOD_W-1:0]   iv_fix;
  logic [TIME_BITS-1:0]  add_a;
  logic [PERIOD_W-1:0]   add_b;
  logic [SUM_W-1:0]      add_sum;
  logic [TIME_BITS-1:0]  add_sat;
  logic                  scan_done;
  logic                  exp_le;
  logic                  better;
  logic [NUM_TIMERS-1:0] remaining;
  logic                  emit_fire;

  // Slot records: expiry, stamp, period and one-shot mark
  mtes_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (NUM_TIMERS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_cnt_q[IDX_W-1:0]),
    .rdata_o (rd_rec)
  );

  // Decode the addressed slot
  assign id_idx = IDX_W'(timer_id_i);
  assign id_ok  = (32'(timer_id_i) < NUM_TIMERS);
  assign iv_fix = (interval_ms_i == '0) ? PERIOD_W'(1) : interval_ms_i;

  // Shared saturating adder: new expiry on start and on periodic re-arm
  assign add_a   = (state_q == ST_IDLE) ? TIME_BITS'(now_ms_i) : now_q;
  assign add_b   = (state_q == ST_IDLE) ? iv_fix : best_rec_q.period;
  assign add_sum = SUM_W'(add_a) + SUM_W'(add_b);
  assign add_sat = (|add_sum[SUM_W-1:TIME_BITS]) ? '1 : add_sum[TIME_BITS-1:0];

  // Shared comparator: is the slot just read due, and does it beat the best so far
  assign scan_done = (scan_cnt_q == CNT_W'(NUM_TIMERS));
  assign exp_le    = (rd_rec.expiry <= now_q);
  assign better    = !found_q || (rd_rec.expiry < best_rec_q.expiry) ||
                     ((rd_rec.expiry == best_rec_q.expiry) &&
                      (rd_rec.stamp > best_rec_q.stamp));

  assign remaining = due_q & ~(NUM_TIMERS'(1) << best_idx_q);

  // Sequencer next state
  always_comb begin
    state_d     = state_q;
    armed_d     = armed_q;
    due_d       = due_q;
    stamp_d     = stamp_q;
    now_d       = now_q;
    scan_cnt_d  = scan_cnt_q;
    rd_vld_d    = rd_vld_q;
    rd_idx_d    = rd_idx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_rec_d  = best_rec_q;
    out_id_d    = out_id_q;
    out_dl_d    = out_dl_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = id_idx;
    ram_wdata   = '{expiry: add_sat, stamp: stamp_q, period: iv_fix, single: one_shot_i};
    emit_fire   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (act_e'(action_i))
            ACT_START: begin
              if (id_ok) begin
                ram_we          = 1'b1;
                armed_d[id_idx] = 1'b1;
                stamp_d         = stamp_q + STAMP_W'(1);
              end
            end
            ACT_STOP: begin
              if (id_ok) begin
                armed_d[id_idx] = 1'b0;
              end
            end
            ACT_TICK: begin
              due_d      = armed_q;
              now_d      = TIME_BITS'(now_ms_i);
              scan_cnt_d = '0;
              rd_vld_d   = 1'b0;
              found_d    = 1'b0;
              state_d    = ST_SCAN;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next read, then judge the slot whose registered read data is now back
        rd_vld_d = !scan_done;
        rd_idx_d = scan_cnt_q[IDX_W-1:0];
        if (!scan_done) begin
          scan_cnt_d = CNT_W'(scan_cnt_q + 1'b1);
        end
        if (rd_vld_q) begin
          if (due_q[rd_idx_q] && !exp_le) begin
            due_d[rd_idx_q] = 1'b0;
          end
          if (due_q[rd_idx_q] && exp_le && better) begin
            found_d    = 1'b1;
            best_idx_d = rd_idx_q;
            best_rec_d = rd_rec;
          end
        end else if (scan_done) begin
          state_d = found_q ? ST_EMIT : ST_IDLE;
        end
      end

      ST_EMIT: begin
        // Hold until the result register is free, then transfer and re-arm
        if (!out_valid_q || out_ready_i) begin
          emit_fire            = 1'b1;
          out_id_d             = ID_W'(best_idx_q);
          out_dl_d             = OUT_TIME_W'(best_rec_q.expiry);
          out_last_d           = (remaining == '0);
          due_d[best_idx_q]    = 1'b0;
          armed_d[best_idx_q]  = !best_rec_q.single;
          if (!best_rec_q.single) begin
            ram_we    = 1'b1;
            ram_waddr = best_idx_q;
            ram_wdata = '{expiry: add_sat, stamp: stamp_q,
                          period: best_rec_q.period, single: 1'b0};
            stamp_d   = stamp_q + STAMP_W'(1);
          end
          scan_cnt_d = '0;
          rd_vld_d   = 1'b0;
          found_d    = 1'b0;
          state_d    = (remaining == '0) ? ST_IDLE : ST_SCAN;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = emit_fire || (out_valid_q && !out_ready_i);

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      armed_q     <= '0;
      due_q       <= '0;
      stamp_q     <= '0;
      scan_cnt_q  <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      due_q       <= due_d;
      stamp_q     <= stamp_d;
      scan_cnt_q  <= scan_cnt_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_rec_q <= best_rec_d;
    out_id_q   <= out_id_d;
    out_dl_q   <= out_dl_d;
    out_last_q <= out_last_d;
  end

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign fired_id_o       = out_id_q;
  assign fired_deadline_o = out_dl_q;
  assign last_of_tick_o   = out_last_q;

  `MTES_ASSERT(a_emit_due, clk_i, rst_ni, (state_q == ST_EMIT) |-> (found_q && due_q[best_idx_q]), "emit without a due slot")
  `MTES_ASSERT(a_stamp_step, clk_i, rst_ni, (stamp_q == $past(stamp_q)) || (stamp_q == $past(stamp_q) + STAMP_W'(1)), "stamp jumped")
  `MTES_ASSERT(a_out_src, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == ST_EMIT), "result not from emit")
  `MTES_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, emit_fire && (remaining == '0), state_q == ST_IDLE, "tick did not end on last result")

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the deadline-ordered timer expiry scheduler.
// Depends on mtes_pkg and multi_timer_expiry_scheduler; predicts each expiry in-line.

module tb;
  import mtes_pkg::*;

  localparam int                    SLOTS         = 16;
  localparam logic [OUT_TIME_W-1:0] TIME_MAX      = '1;
  localparam logic [PERIOD_W-1:0]   PERIOD_MAX    = '1;
  localparam logic [1:0]            ACT_UNUSED    = 2'd3;
  // one full scan plus one fire, taken twice over
  localparam int                    SETTLE_CYCLES = 2 * (SLOTS + 3);

  typedef logic [OUT_TIME_W-1:0] ms_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    ms_t             deadline;
    logic            last;
  } expiry_t;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [1:0]            action         = '0;
  logic [ID_W-1:0]       timer_id       = '0;
  logic [PERIOD_W-1:0]   interval_ms    = '0;
  logic                  one_shot       = 1'b0;
  ms_t                   now_ms         = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [ID_W-1:0]       fired_id;
  ms_t                   fired_deadline;
  logic                  last_of_tick;

  // Shadow of the slot table
  ms_t                   slot_expiry [SLOTS];
  logic [PERIOD_W-1:0]   slot_period [SLOTS];
  logic                  slot_once   [SLOTS];
  logic                  slot_armed  [SLOTS];
  logic [STAMP_W-1:0]    slot_stamp  [SLOTS];
  logic [STAMP_W-1:0]    stamp_next;

  expiry_t               pending_expiries[$];
  ms_t                   wall_ms    = '0;
  bit                    gaps_tx    = 1'b1;
  bit                    stall_rx   = 1'b1;
  int                    mismatches = 0;

  multi_timer_expiry_scheduler uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (action),
    .timer_id_i       (timer_id),
    .interval_ms_i    (interval_ms),
    .one_shot_i       (one_shot),
    .now_ms_i         (now_ms),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .fired_id_o       (fired_id),
    .fired_deadline_o (fired_deadline),
    .last_of_tick_o   (last_of_tick)
  );

  always #5 clk = ~clk;

  // Deadline of a slot armed at now, held at the top of the time range
  function automatic ms_t deadline_after(ms_t now, logic [PERIOD_W-1:0] iv);
    logic [OUT_TIME_W:0] sum;
    sum = {1'b0, now} + iv;
    return sum[OUT_TIME_W] ? TIME_MAX : sum[OUT_TIME_W-1:0];
  endfunction

  function automatic void requeue_slot(int s, ms_t now);
    slot_expiry[s] = deadline_after(now, slot_period[s]);
    slot_stamp[s]  = stamp_next;
    stamp_next     = stamp_next + 1;
    slot_armed[s]  = 1'b1;
  endfunction

  // Earlier deadline first, then the newer stamp, then the lower slot
  function automatic bit fires_first(int a, int b);
    if (slot_expiry[a] != slot_expiry[b]) return slot_expiry[a] < slot_expiry[b];
    if (slot_stamp[a] != slot_stamp[b]) return slot_stamp[a] > slot_stamp[b];
    return a < b;
  endfunction

  // Advance the shadow table by one accepted transfer and queue its expiries
  function automatic void apply_item(logic [1:0] act, logic [ID_W-1:0] id,
                                     logic [PERIOD_W-1:0] iv, logic once, ms_t now);
    logic    due [SLOTS];
    int      fire_order [SLOTS];
    int      fired;
    int      pick;
    expiry_t hit;
    fired = 0;
    case (act)
      ACT_START: begin
        slot_period[id] = (iv == '0) ? PERIOD_W'(1) : iv;
        slot_once[id]   = once;
        requeue_slot(id, now);
      end
      ACT_STOP: begin
        slot_armed[id] = 1'b0;
      end
      ACT_TICK: begin
        for (int s = 0; s < SLOTS; s++) due[s] = slot_armed[s] && (slot_expiry[s] <= now);
        pick = 0;
        while (pick >= 0) begin
          pick = -1;
          for (int s = 0; s < SLOTS; s++)
            if (due[s] && (pick < 0 || fires_first(s, pick))) pick = s;
          if (pick >= 0) begin
            due[pick]         = 1'b0;
            fire_order[fired] = pick;
            fired             = fired + 1;
          end
        end
        // Emit in order, re-arming periodic slots as they go
        for (int k = 0; k < fired; k++) begin
          hit.id       = ID_W'(fire_order[k]);
          hit.deadline = slot_expiry[fire_order[k]];
          hit.last     = (k == fired - 1);
          pending_expiries.push_back(hit);
          slot_armed[fire_order[k]] = 1'b0;
          if (!slot_once[fire_order[k]]) requeue_slot(fire_order[k], now);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Offer one transfer at the current wall time and hold it until taken
  task automatic send_item(logic [1:0] act, logic [ID_W-1:0] id,
                           logic [PERIOD_W-1:0] iv, logic once);
    @(negedge clk);
    while (gaps_tx && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    timer_id    <= id;
    interval_ms <= iv;
    one_shot    <= once;
    now_ms      <= wall_ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_item(act, id, iv, once, wall_ms);
  endtask

  // Hold off the sender until every queued expiry has been seen
  task automatic await_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_expiries.size() != 0) @(posedge clk);
  endtask

  // Empty tick, stop of an idle slot and the unused action
  task automatic test_idle_actions();
    wall_ms = '0;
    send_item(ACT_TICK, ID_W'($urandom), PERIOD_W'($urandom), 1'($urandom));
    send_item(ACT_STOP, 4'd3, PERIOD_W'($urandom), 1'b0);
    send_item(ACT_UNUSED, ID_W'($urandom), PERIOD_W'($urandom), 1'($urandom));
  endtask

  // Arm every slot, then fire them all at once; covers ties, restart and stop
  task automatic test_full_queue();
    logic [PERIOD_W-1:0] iv;
    wall_ms = 48'd100;
    for (int s = 0; s < SLOTS; s++) begin
      if (s == 0) iv = '0;
      else if (s <= 4) iv = 31'd10;
      else if (s == SLOTS - 1) iv = PERIOD_MAX;
      else iv = PERIOD_W'(5 * s);
      send_item(ACT_START, ID_W'(s), iv, s[0]);
    end
    wall_ms = 48'd102;
    send_item(ACT_START, 4'd2, 31'd8, 1'b0);
    wall_ms = 48'd100 + 48'h8000_0000 + 48'd5;
    send_item(ACT_TICK, 4'd0, '0, 1'b0);
    send_item(ACT_TICK, 4'd15, '0, 1'b0);
    send_item(ACT_STOP, 4'd0, '0, 1'b0);
    wall_ms = wall_ms + 48'd50;
    send_item(ACT_TICK, 4'd0, '0, 1'b0);
  endtask

  // Random mix of starts, stops and ticks with nondecreasing time
  task automatic test_random_traffic(int count, bit with_idling);
    int                  counted;
    int                  pick;
    logic [1:0]          act;
    logic [PERIOD_W-1:0] iv;
    counted  = 0;
    gaps_tx  = with_idling;
    stall_rx = with_idling;
    while (counted < count) begin
      pick = $urandom_range(99);
      if (pick < 40) act = ACT_START;
      else if (pick < 55) act = ACT_STOP;
      else if (pick < 60) act = ACT_UNUSED;
      else act = ACT_TICK;
      // advance the wall clock, now and then by a large jump
      pick = $urandom_range(99);
      if (pick < 2) wall_ms = wall_ms + OUT_TIME_W'($urandom);
      else if (pick < 70) wall_ms = wall_ms + OUT_TIME_W'($urandom_range(3));
      if (act == ACT_TICK) wall_ms = wall_ms + OUT_TIME_W'($urandom_range(25));
      pick = $urandom_range(99);
      if (pick < 70) iv = PERIOD_W'($urandom_range(1, 30));
      else if (pick < 90) iv = PERIOD_W'($urandom_range(31, 1000));
      else iv = PERIOD_W'($urandom);
      send_item(act, ID_W'($urandom), iv, $urandom_range(99) < 30);
      if (act != ACT_UNUSED) counted++;
    end
    gaps_tx  = 1'b1;
    stall_rx = 1'b1;
  endtask

  // Deadlines at the top of the time range, saturated and exact
  task automatic test_deadline_saturation();
    wall_ms = TIME_MAX - 48'd5;
    send_item(ACT_START, 4'd3, PERIOD_MAX, 1'b0);
    send_item(ACT_START, 4'd9, 31'd5, 1'b1);
    wall_ms = TIME_MAX - 48'd1;
    send_item(ACT_TICK, 4'd0, '0, 1'b0);
    wall_ms = TIME_MAX;
    send_item(ACT_TICK, 4'd0, '0, 1'b0);
    send_item(ACT_TICK, 4'd0, '0, 1'b0);
  endtask

  // Result side back-pressure
  always @(negedge clk) begin
    out_ready <= (stall_rx && $urandom_range(99) < 29) ? 1'b0 : 1'b1;
  end

  // Compare each result transfer with the oldest predicted expiry
  always @(posedge clk) begin : check_expiry
    expiry_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_expiries.size() == 0) begin
        $display("%0t: unexpected expiry: id %0d deadline %0d last %0b", $time,
                 fired_id, fired_deadline, last_of_tick);
        mismatches++;
      end else begin
        want = pending_expiries.pop_front();
        if (fired_id !== want.id) begin
          $display("%0t: fired_id expected %0d actual %0d", $time, want.id, fired_id);
          mismatches++;
        end
        if (fired_deadline !== want.deadline) begin
          $display("%0t: fired_deadline expected %0d actual %0d", $time,
                   want.deadline, fired_deadline);
          mismatches++;
        end
        if (last_of_tick !== want.last) begin
          $display("%0t: last_of_tick expected %0b actual %0b", $time,
                   want.last, last_of_tick);
          mismatches++;
        end
      end
    end
  end

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      slot_expiry[s] = '0;
      slot_period[s] = '0;
      slot_once[s]   = 1'b0;
      slot_armed[s]  = 1'b0;
      slot_stamp[s]  = '0;
    end
    stamp_next = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_actions();
    test_full_queue();
    await_drain();
    test_random_traffic(150, 1'b1);
    await_drain();
    test_random_traffic(80, 1'b0);
    await_drain();
    test_random_traffic(140, 1'b1);
    test_deadline_saturation();
    await_drain();
    stall_rx = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Bound the run well beyond the slowest legal progress
  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
